[src/sdpg_pkg.sv]
// Shared types and codes for the step/direction pulse generator.
package sdpg_pkg;

   localparam int unsigned WordWidth   = 32;
   localparam int unsigned CsrIdxWidth = 3;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_START   = 2'd1,
      CMD_STOP    = 2'd2,
      CMD_REVERSE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_FREE     = 2'd0,
      MODE_POSITION = 2'd1,
      MODE_COUNT    = 2'd2,
      MODE_ZERO     = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_STOPPED    = 3'd0,
      ST_RUNNING    = 3'd1,
      ST_AT_TARGET  = 3'd2,
      ST_COUNT_DONE = 3'd3,
      ST_ZERO_FOUND = 3'd4
   } status_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      REG_MOVE_MODE     = 3'd0,
      REG_TARGET_POS    = 3'd1,
      REG_STEP_COUNT    = 3'd2,
      REG_STEP_PERIOD   = 3'd3,
      REG_PULSE_WIDTH   = 3'd4,
      REG_MOTION_ENABLE = 3'd5,
      REG_INVERT_SENSOR = 3'd6,
      REG_SENSOR_ALWAYS = 3'd7
   } csr_idx_type;

   // Configuration as seen by the step engine
   typedef struct packed {
      mode_type                     move_mode;
      logic signed [WordWidth-1:0]  target_position;
      logic [WordWidth-1:0]         step_count;
      logic [WordWidth-1:0]         step_period;
      logic [WordWidth-1:0]         pulse_width;
      logic                         motion_enable;
      logic                         invert_sensor;
      logic                         sensor_always_watched;
   } cfg_type;

   // Visible result of one command
   typedef struct packed {
      logic                         pulse_level;
      logic                         direction;
      logic signed [WordWidth-1:0]  position;
      status_type                   status;
   } view_type;

endpackage

[src/sdpg_core.sv]
// Step engine: motion state registers and the per-command update logic.
module sdpg_core (
   input  logic             clock,
   input  logic             reset,
   input  sdpg_pkg::cfg_type cfg,
   input  logic             beat_en,
   input  logic [1:0]       cmd,
   input  logic             sensor_level,
   output sdpg_pkg::view_type view_in
);
   import sdpg_pkg::*;

   logic                        pulse_active_ff, pulse_active_in;
   logic [WordWidth-1:0]        pulse_ticks_ff, pulse_ticks_in;
   logic [WordWidth-1:0]        period_ticks_ff, period_ticks_in;
   logic signed [WordWidth-1:0] position_ff, position_in;
   logic [WordWidth-1:0]        remaining_ff, remaining_in;
   logic                        running_ff, running_in;
   logic                        dir_up_ff, dir_up_in;
   logic                        sensor_prev_ff, sensor_prev_in;
   status_type                  status_ff, status_in;
   cmd_type                     cmd_c;
   logic                        level;

   assign cmd_c = cmd_type'(cmd);
   assign level = sensor_level ^ cfg.invert_sensor;

   // Next state for the command in this beat
   always_comb begin
      pulse_active_in = pulse_active_ff;
      pulse_ticks_in  = pulse_ticks_ff;
      period_ticks_in = period_ticks_ff;
      position_in     = position_ff;
      remaining_in    = remaining_ff;
      running_in      = running_ff;
      dir_up_in       = dir_up_ff;
      sensor_prev_in  = sensor_prev_ff;
      status_in       = status_ff;
      case (cmd_c)
         CMD_TICK: begin
            // pulse width timing
            if (pulse_active_ff) begin
               if (pulse_ticks_ff < cfg.pulse_width) begin
                  pulse_ticks_in = pulse_ticks_ff + 1'b1;
               end else begin
                  pulse_ticks_in  = '0;
                  pulse_active_in = 1'b0;
               end
            end
            if (running_ff && cfg.motion_enable) begin
               if (period_ticks_ff < cfg.step_period) begin
                  period_ticks_in = period_ticks_ff + 1'b1;
               end else begin
                  // emit a step
                  pulse_ticks_in  = '0;
                  period_ticks_in = '0;
                  pulse_active_in = 1'b1;
                  position_in     = dir_up_ff ? position_ff + WordWidth'(1)
                                              : position_ff - WordWidth'(1);
                  if (cfg.move_mode == MODE_POSITION && position_in == cfg.target_position) begin
                     running_in = 1'b0;
                     status_in  = ST_AT_TARGET;
                  end
                  if (cfg.move_mode == MODE_COUNT) begin
                     if (remaining_ff == '0) begin
                        running_in = 1'b0;
                        status_in  = ST_COUNT_DONE;
                     end else begin
                        remaining_in = remaining_ff - 1'b1;
                     end
                  end
                  // zero sensor edge
                  if (cfg.move_mode == MODE_ZERO || cfg.sensor_always_watched) begin
                     sensor_prev_in = level;
                     if (level && !sensor_prev_ff) begin
                        position_in = '0;
                        if (cfg.move_mode == MODE_ZERO) begin
                           running_in = 1'b0;
                           status_in  = ST_ZERO_FOUND;
                        end
                     end
                  end
               end
            end
         end
         CMD_START: begin
            running_in      = 1'b1;
            remaining_in    = cfg.step_count;
            period_ticks_in = '0;
            status_in       = ST_RUNNING;
         end
         CMD_STOP: begin
            running_in = 1'b0;
            status_in  = ST_STOPPED;
         end
         CMD_REVERSE: begin
            dir_up_in = !dir_up_ff;
         end
         default: begin
            dir_up_in = dir_up_ff;
         end
      endcase
   end

   assign view_in.pulse_level = pulse_active_in;
   assign view_in.direction   = dir_up_in;
   assign view_in.position    = position_in;
   assign view_in.status      = status_in;

   // State update on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_active_ff <= 1'b0;
         pulse_ticks_ff  <= '0;
         period_ticks_ff <= '0;
         position_ff     <= '0;
         remaining_ff    <= '0;
         running_ff      <= 1'b0;
         dir_up_ff       <= 1'b0;
         sensor_prev_ff  <= 1'b0;
         status_ff       <= ST_STOPPED;
      end else if (beat_en) begin
         pulse_active_ff <= pulse_active_in;
         pulse_ticks_ff  <= pulse_ticks_in;
         period_ticks_ff <= period_ticks_in;
         position_ff     <= position_in;
         remaining_ff    <= remaining_in;
         running_ff      <= running_in;
         dir_up_ff       <= dir_up_in;
         sensor_prev_ff  <= sensor_prev_in;
         status_ff       <= status_in;
      end
   end

   // Running flag and running status always agree
   a_run_status: assert property (@(posedge clock) disable iff (reset)
      running_ff == (status_ff == ST_RUNNING))
      else $error("running flag and status disagree");

   // Reverse only flips direction and leaves position alone
   a_reverse: assert property (@(posedge clock) disable iff (reset)
      beat_en && cmd_c == CMD_REVERSE |=>
         dir_up_ff != $past(dir_up_ff) && $stable(position_ff))
      else $error("reverse did not toggle direction cleanly");

   // State holds between beats
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !beat_en |=> $stable(position_ff) && $stable(running_ff) && $stable(pulse_ticks_ff))
      else $error("state changed without a beat");

   // A new pulse starts only on a tick
   a_pulse_rise: assert property (@(posedge clock) disable iff (reset)
      beat_en && !pulse_active_ff && pulse_active_in |-> cmd_c == CMD_TICK)
      else $error("pulse started outside a tick");

endmodule

[src/step_dir_pulse_generator_unit.sv]
// Top level: step/direction pulse generator with command and result channels.
//
// Usage:
//  - req_ channel: one command per beat (tick, start, stop, reverse) plus the
//    raw zero sensor level; the sensor is only looked at on a tick that steps.
//  - rsp_ channel: one result per command: pulse level, direction, position
//    and move status as they stand after that command.
//  - csr_ port: write-only registers, one write per cycle when csr_write_en
//    is high; write only while no command is in flight.
// The result of a command is offered in the cycle after its request beat
// is accepted. Throughput: one command per cycle while rsp_ready keeps up;
// the state update of each command is a single pass of compares and +/-1
// counters between the motion state registers and the result register.
// Reset: synchronous; clears the configuration registers, motion state and the result valid.
// Stall: while rsp_valid is high and rsp_ready is low, req_ready is low; a
// new request is taken in the same cycle a waiting result is taken.
module step_dir_pulse_generator_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_cmd,
   input  logic                                req_sensor_level,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_pulse_level,
   output logic                                rsp_direction,
   output logic signed [sdpg_pkg::WordWidth-1:0] rsp_position,
   output logic [2:0]                          rsp_status,
   input  logic                                csr_write_en,
   input  logic [sdpg_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [sdpg_pkg::WordWidth-1:0]      csr_wdata
);
   import sdpg_pkg::*;

   cfg_type  cfg_ff;
   view_type view_in;
   view_type view_ff;
   logic     rsp_valid_ff;
   logic     beat_en;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign beat_en   = req_valid && req_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_idx_type'(csr_index))
            REG_MOVE_MODE:     cfg_ff.move_mode <= mode_type'(csr_wdata[1:0]);
            REG_TARGET_POS:    cfg_ff.target_position <= csr_wdata;
            REG_STEP_COUNT:    cfg_ff.step_count <= csr_wdata;
            REG_STEP_PERIOD:   cfg_ff.step_period <= csr_wdata;
            REG_PULSE_WIDTH:   cfg_ff.pulse_width <= csr_wdata;
            REG_MOTION_ENABLE: cfg_ff.motion_enable <= csr_wdata[0];
            REG_INVERT_SENSOR: cfg_ff.invert_sensor <= csr_wdata[0];
            REG_SENSOR_ALWAYS: cfg_ff.sensor_always_watched <= csr_wdata[0];
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   sdpg_core u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .beat_en      (beat_en),
      .cmd          (req_cmd),
      .sensor_level (req_sensor_level),
      .view_in      (view_in)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (beat_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (beat_en) begin
         view_ff <= view_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pulse_level = view_ff.pulse_level;
   assign rsp_direction   = view_ff.direction;
   assign rsp_position    = view_ff.position;
   assign rsp_status      = view_ff.status;

endmodule
